// File: rtl/pcfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfs_pkg
// Types and constants shared by the fragment statistics block: item formats,
// table row layout and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package pcfs_pkg;

    // Field widths fixed by the item format.
    localparam int CHAN_ADDR_W   = 12;
    localparam int ADDR_MAX_BITS = 16;   // widest table address supported
    localparam int DET_TYPE_W    = 4;
    localparam int DET_TYPES     = 2 ** DET_TYPE_W;

    localparam logic [30:0] PACKET_MIN_RESET = 31'h7fff_ffff;
    localparam logic [31:0] MAX32            = 32'hffff_ffff;
    localparam logic [47:0] MAX48            = 48'hffff_ffff_ffff;

    typedef struct packed {
        logic [11:0] channel_address;
        logic [31:0] channel_id;
        logic [31:0] dead_time;
        logic [47:0] timestamp_ns;
        logic [3:0]  detector_type;
        logic [30:0] packet_number;
        logic [31:0] daq_time;
    } pcfs_in_t;

    typedef struct packed {
        logic [31:0] hit_count;
        logic [47:0] dead_time_total;
        logic [31:0] lowest_id;
        logic [31:0] highest_id;
        logic [47:0] earliest_time;
        logic [47:0] latest_time;
        logic [31:0] type_total;
        logic [31:0] packets_seen;
        logic [30:0] lowest_packet;
        logic [30:0] highest_packet;
        logic [31:0] first_daq_time;
        logic [31:0] last_daq_time;
    } pcfs_out_t;

    // One row of the per-channel table.
    typedef struct packed {
        logic        valid;
        logic [31:0] hits;
        logic [47:0] dead_sum;
        logic [31:0] min_id;
        logic [31:0] max_id;
        logic [47:0] min_time;
        logic [47:0] max_time;
    } pcfs_row_t;

    // Controller -> datapath
    typedef struct packed {
        logic clear_step;   // write one zero row of the clearing sweep
        logic load_item;    // capture the accepted input item
        logic read_row;     // read the table row of the held item
        logic commit;       // write back row, update globals, load result
    } pcfs_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;   // sweep is at the last row
        logic out_free;     // result register can take a new item
    } pcfs_status_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        sat_inc32 = (v == MAX32) ? v : v + 32'd1;
    endfunction

endpackage : pcfs_pkg
`default_nettype wire

// File: rtl/per_channel_fragment_statistics.sv
// Flow: an accepted item is captured, its row is read into a register, then
//   write-back (held while the result register is occupied) updates the row,
//   loads the result onto m_valid and only then lets in the next item.
// Reset: aresetn (synchronous, active low) clears counters and control, then
//   a clearing pass over all 2**ADDRESS_BITS rows (4096 by default) zeroes the
//   channel table; s_ready stays low until it finishes.
`default_nettype none
// ----------------------------------------------------------------------------
// per_channel_fragment_statistics
// Per-channel hit/dead-time/id/time statistics table plus global detector
// type, packet number and acquisition time statistics, one result per item.
// ----------------------------------------------------------------------------
module per_channel_fragment_statistics
    import pcfs_pkg::*;
#(
    parameter int ADDRESS_BITS = 12,    // table depth is 2**ADDRESS_BITS
    parameter int TYPE_COUNT   = 16     // detector types with a counter
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // fragment input
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire pcfs_in_t s_data,
    // statistics result
    output logic          m_valid,
    input  wire logic     m_ready,
    output pcfs_out_t     m_data
);

    // Controller and datapath talk only through these two bundles.
    pcfs_cmd_t    cmd;
    pcfs_status_t status;

    // Sequencer: sweep after reset, then accept -> read row -> write back.
    // The write-back waits while the result register is still occupied.
    pcfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Table memory (valid mark stored in each row, cleared by the sweep),
    // update logic, type counters, packet and acquisition time tracking,
    // and the output register that decouples m_ready from the input side.
    pcfs_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .TYPE_COUNT   (TYPE_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule : per_channel_fragment_statistics
`default_nettype wire

// File: rtl/pcfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfs_ctrl
// Sequencer: clearing sweep after reset, then accept / read / write-back
// for one item at a time.
// ----------------------------------------------------------------------------
module pcfs_ctrl
    import pcfs_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire pcfs_status_t status,
    output pcfs_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next     = state_reg;
        s_ready_next   = s_ready_reg;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_last) begin
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_READ;
                    s_ready_next  = 1'b0;
                end
            end
            ST_READ: begin
                cmd.read_row = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    cmd.commit   = 1'b1;
                    state_next   = ST_IDLE;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = ST_CLEAR;
                s_ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule : pcfs_ctrl
`default_nettype wire

// File: rtl/pcfs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcfs_datapath
// Channel table memory, update arithmetic, global counters and the result
// register.
// ----------------------------------------------------------------------------
module pcfs_datapath
    import pcfs_pkg::*;
#(
    parameter int ADDRESS_BITS = 12,
    parameter int TYPE_COUNT   = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire pcfs_in_t     s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output pcfs_out_t         m_data,
    input  wire pcfs_cmd_t    cmd,
    output pcfs_status_t      status
);

    localparam int DEPTH      = 2 ** ADDRESS_BITS;
    // detector_type is 4 bits wide, so at most 16 counters can ever be hit
    localparam int TYPE_DEPTH = (TYPE_COUNT < DET_TYPES) ? TYPE_COUNT : DET_TYPES;
    localparam int TIDX_BITS  = $clog2(TYPE_DEPTH);

    pcfs_row_t                 mem [DEPTH];
    pcfs_row_t                 rd_reg;
    pcfs_in_t                  item_reg;
    pcfs_out_t                 m_data_reg;
    logic                      m_valid_reg;
    logic [ADDRESS_BITS-1:0]   clr_addr_reg;
    logic [31:0]               type_cnt_reg [TYPE_DEPTH];
    logic [31:0]               pkt_total_reg;
    logic [30:0]               pkt_min_reg;
    logic [30:0]               pkt_max_reg;
    logic [31:0]               daq_min_reg;
    logic [31:0]               daq_max_reg;

    logic [ADDR_MAX_BITS-1:0]  addr_wide;
    logic [ADDRESS_BITS-1:0]   item_addr;
    logic [TIDX_BITS-1:0]      tidx;
    logic                      type_ok;
    logic [31:0]               type_new;
    logic [48:0]               dead_add;
    pcfs_row_t                 row_new;
    logic                      pkt_hit;
    logic [31:0]               pkt_total_new;
    logic [30:0]               pkt_min_new;
    logic [30:0]               pkt_max_new;
    logic [31:0]               daq_min_new;
    logic [31:0]               daq_max_new;
    logic                      mem_we;
    logic [ADDRESS_BITS-1:0]   mem_waddr;
    pcfs_row_t                 mem_wdata;

    // Address wraps to the table size.
    assign addr_wide = ADDR_MAX_BITS'(item_reg.channel_address);
    assign item_addr = addr_wide[ADDRESS_BITS-1:0];

    assign type_ok  = (32'(item_reg.detector_type) < 32'(TYPE_COUNT));
    assign tidx     = item_reg.detector_type[TIDX_BITS-1:0];
    assign type_new = sat_inc32(type_cnt_reg[tidx]);

    // Row update
    assign dead_add = {1'b0, rd_reg.dead_sum} + 49'(item_reg.dead_time);

    always_comb begin
        row_new.valid = 1'b1;
        if (!rd_reg.valid) begin
            row_new.hits     = 32'd1;
            row_new.dead_sum = 48'(item_reg.dead_time);
            row_new.min_id   = item_reg.channel_id;
            row_new.max_id   = item_reg.channel_id;
            row_new.min_time = item_reg.timestamp_ns;
            row_new.max_time = item_reg.timestamp_ns;
        end else begin
            row_new.hits     = sat_inc32(rd_reg.hits);
            row_new.dead_sum = dead_add[48] ? MAX48 : dead_add[47:0];
            row_new.min_id   = (item_reg.channel_id < rd_reg.min_id) ?
                               item_reg.channel_id : rd_reg.min_id;
            row_new.max_id   = (item_reg.channel_id > rd_reg.max_id) ?
                               item_reg.channel_id : rd_reg.max_id;
            row_new.min_time = (item_reg.timestamp_ns < rd_reg.min_time) ?
                               item_reg.timestamp_ns : rd_reg.min_time;
            row_new.max_time = (item_reg.timestamp_ns > rd_reg.max_time) ?
                               item_reg.timestamp_ns : rd_reg.max_time;
        end
    end

    // Global statistics
    assign pkt_hit       = (item_reg.packet_number != 31'd0);
    assign pkt_total_new = pkt_hit ? sat_inc32(pkt_total_reg) : pkt_total_reg;
    assign pkt_min_new   = (pkt_hit && (item_reg.packet_number < pkt_min_reg)) ?
                           item_reg.packet_number : pkt_min_reg;
    assign pkt_max_new   = (pkt_hit && (item_reg.packet_number > pkt_max_reg)) ?
                           item_reg.packet_number : pkt_max_reg;
    // zero means unset: a stored zero always gives way
    assign daq_min_new   = ((daq_min_reg == 32'd0) || (item_reg.daq_time < daq_min_reg)) ?
                           item_reg.daq_time : daq_min_reg;
    assign daq_max_new   = ((daq_max_reg == 32'd0) || (item_reg.daq_time > daq_max_reg)) ?
                           item_reg.daq_time : daq_max_reg;

    // Table memory: one write port (sweep or write-back), one registered read.
    assign mem_we    = cmd.clear_step || cmd.commit;
    assign mem_waddr = cmd.clear_step ? clr_addr_reg : item_addr;
    assign mem_wdata = cmd.clear_step ? pcfs_row_t'('0) : row_new;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read_row) begin
            rd_reg <= mem[item_addr];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.commit) begin
            m_data_reg.hit_count       <= row_new.hits;
            m_data_reg.dead_time_total <= row_new.dead_sum;
            m_data_reg.lowest_id       <= row_new.min_id;
            m_data_reg.highest_id      <= row_new.max_id;
            m_data_reg.earliest_time   <= row_new.min_time;
            m_data_reg.latest_time     <= row_new.max_time;
            m_data_reg.type_total      <= type_ok ? type_new : 32'd0;
            m_data_reg.packets_seen    <= pkt_total_new;
            m_data_reg.lowest_packet   <= pkt_min_new;
            m_data_reg.highest_packet  <= pkt_max_new;
            m_data_reg.first_daq_time  <= daq_min_new;
            m_data_reg.last_daq_time   <= daq_max_new;
        end
    end

    // Control state and global counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            clr_addr_reg  <= '0;
            pkt_total_reg <= '0;
            pkt_min_reg   <= PACKET_MIN_RESET;
            pkt_max_reg   <= '0;
            daq_min_reg   <= '0;
            daq_max_reg   <= '0;
            for (int i = 0; i < TYPE_DEPTH; i++) begin
                type_cnt_reg[i] <= '0;
            end
        end else begin
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.commit) begin
                m_valid_reg   <= 1'b1;
                pkt_total_reg <= pkt_total_new;
                pkt_min_reg   <= pkt_min_new;
                pkt_max_reg   <= pkt_max_new;
                daq_min_reg   <= daq_min_new;
                daq_max_reg   <= daq_max_new;
                if (type_ok) begin
                    type_cnt_reg[tidx] <= type_new;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = &clr_addr_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed item not presented");

    a_hits_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.hit_count != 32'd0))
        else $error("result with zero hit count");

    a_id_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.lowest_id <= m_data_reg.highest_id))
        else $error("channel id min above max");

    a_time_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.earliest_time <= m_data_reg.latest_time))
        else $error("channel time min above max");
`endif

endmodule : pcfs_datapath
`default_nettype wire
